>>> rtl/cbac_pkg.sv
// Shared types and constants of the contiguous block allocator.
// Holds the control word layout, step codes and result status codes.
`default_nettype none

package cbac_pkg;

   localparam int NUM_BLOCKS_DEF = 256;
   localparam int SIZE_W         = 24;
   localparam int IDX_W          = 8;
   localparam int BLOCK_SHIFT    = 12;               // 4096-byte blocks
   localparam int NEED_W         = SIZE_W - BLOCK_SHIFT + 1;
   localparam int ENTRY_W        = IDX_W + 2;        // busy, next link, end mark
   localparam int STEP_W         = 4;

   typedef enum logic [1:0] {
      STAT_ALLOC  = 2'd0,
      STAT_NOROOM = 2'd1,
      STAT_READ   = 2'd2
   } status_type;

   typedef enum logic [STEP_W-1:0] {
      S_CLR       = 4'd0,
      S_IDLE      = 4'd1,
      S_DISP      = 4'd2,
      S_CHK       = 4'd3,
      S_SCAN_RD   = 4'd4,
      S_SCAN_EV   = 4'd5,
      S_SCAN_NEXT = 4'd6,
      S_NOROOM    = 4'd7,
      S_RD        = 4'd8,
      S_RD_EV     = 4'd9,
      S_WR_INIT   = 4'd10,
      S_WR        = 4'd11,
      S_DONE      = 4'd12
   } step_type;

   typedef enum logic [3:0] {
      ACT_NOP,
      ACT_CLR,
      ACT_ACCEPT,
      ACT_SCAN_RD,
      ACT_SCAN_EV,
      ACT_RD_ISSUE,
      ACT_WR_INIT,
      ACT_WR,
      ACT_RSP_NOROOM,
      ACT_RSP_READ,
      ACT_RSP_OK
   } act_type;

   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_OP_READ,
      COND_TOO_BIG,
      COND_FOUND,
      COND_NOT_END,
      COND_NOT_WR_LAST,
      COND_NOT_CLR_LAST
   } cond_type;

   typedef struct packed {
      act_type  act;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   typedef struct packed {
      logic req_valid;
      logic op_read;
      logic too_big;
      logic found;
      logic cnt_end;
      logic wr_last;
      logic clr_last;
      logic slot_free;
   } dp_flags_type;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_READ  = 1'b1;

endpackage

`default_nettype wire

>>> rtl/cbac_if.sv
// Request and response channel interfaces of the block allocator.
// Depends on cbac_pkg for field widths.
`default_nettype none

interface cbac_req_if import cbac_pkg::*; ;
   logic              valid;
   logic              ready;
   logic              opcode;
   logic [SIZE_W-1:0] size_bytes;
   logic [IDX_W-1:0]  entry_index;

   modport source (output valid, opcode, size_bytes, entry_index, input ready);
   modport sink   (input valid, opcode, size_bytes, entry_index, output ready);
endinterface

interface cbac_rsp_if import cbac_pkg::*; ;
   logic             valid;
   logic             ready;
   logic [1:0]       status;
   logic [IDX_W-1:0] start_block;
   logic             entry_busy;
   logic [IDX_W-1:0] entry_next;
   logic             entry_end;

   modport source (output valid, status, start_block, entry_busy, entry_next, entry_end,
                   input ready);
   modport sink   (input valid, status, start_block, entry_busy, entry_next, entry_end,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/cbac_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cbac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/cbac_seq.sv
// Microcode sequencer: step counter, control ROM and jump logic.
// Depends on cbac_pkg for the control word and flag types.
`default_nettype none

module cbac_seq import cbac_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire dp_flags_type  flags,
   output ctrl_word_type      ctrl
);

   function automatic ctrl_word_type rom(input step_type pc);
      ctrl_word_type w;
      w = '{act: ACT_NOP, cond: COND_ALWAYS, target: S_IDLE};
      case (pc)
         S_CLR:       w = '{act: ACT_CLR,        cond: COND_NOT_CLR_LAST, target: S_CLR};
         S_IDLE:      w = '{act: ACT_ACCEPT,     cond: COND_NO_REQ,       target: S_IDLE};
         S_DISP:      w = '{act: ACT_NOP,        cond: COND_OP_READ,      target: S_RD};
         S_CHK:       w = '{act: ACT_NOP,        cond: COND_TOO_BIG,      target: S_NOROOM};
         S_SCAN_RD:   w = '{act: ACT_SCAN_RD,    cond: COND_NEVER,        target: S_IDLE};
         S_SCAN_EV:   w = '{act: ACT_SCAN_EV,    cond: COND_FOUND,        target: S_WR_INIT};
         S_SCAN_NEXT: w = '{act: ACT_NOP,        cond: COND_NOT_END,      target: S_SCAN_RD};
         S_NOROOM:    w = '{act: ACT_RSP_NOROOM, cond: COND_ALWAYS,       target: S_IDLE};
         S_RD:        w = '{act: ACT_RD_ISSUE,   cond: COND_NEVER,        target: S_IDLE};
         S_RD_EV:     w = '{act: ACT_RSP_READ,   cond: COND_ALWAYS,       target: S_IDLE};
         S_WR_INIT:   w = '{act: ACT_WR_INIT,    cond: COND_NEVER,        target: S_IDLE};
         S_WR:        w = '{act: ACT_WR,         cond: COND_NOT_WR_LAST,  target: S_WR};
         S_DONE:      w = '{act: ACT_RSP_OK,     cond: COND_ALWAYS,       target: S_IDLE};
         default:     w = '{act: ACT_NOP,        cond: COND_ALWAYS,       target: S_IDLE};
      endcase
      return w;
   endfunction

   step_type      pc_ff;
   step_type      pc_in;
   ctrl_word_type word;
   logic          hold;
   logic          take;

   assign word = rom(pc_ff);

   // Hold a response step until the output register is free.
   assign hold = (word.act == ACT_RSP_NOROOM || word.act == ACT_RSP_READ ||
                  word.act == ACT_RSP_OK) && !flags.slot_free;

   always_comb begin
      case (word.cond)
         COND_NEVER:        take = 1'b0;
         COND_ALWAYS:       take = 1'b1;
         COND_NO_REQ:       take = !flags.req_valid;
         COND_OP_READ:      take = flags.op_read;
         COND_TOO_BIG:      take = flags.too_big;
         COND_FOUND:        take = flags.found;
         COND_NOT_END:      take = !flags.cnt_end;
         COND_NOT_WR_LAST:  take = !flags.wr_last;
         COND_NOT_CLR_LAST: take = !flags.clr_last;
         default:           take = 1'b0;
      endcase
   end

   always_comb begin
      if (hold) begin
         pc_in = pc_ff;
      end else if (take) begin
         pc_in = word.target;
      end else begin
         pc_in = step_type'(pc_ff + 1'b1);
      end
   end

   assign ctrl = hold ? ctrl_word_type'{act: ACT_NOP, cond: COND_NEVER, target: S_IDLE} : word;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= S_CLR;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/cbac_dp.sv
// Datapath of the block allocator: request capture, scan and link counters,
// block table RAM and the response register. Depends on cbac_pkg, cbac_if, cbac_ram.
`default_nettype none

module cbac_dp import cbac_pkg::*; #(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire ctrl_word_type ctrl,
   output dp_flags_type       flags,
   cbac_req_if.sink           req_ch,
   cbac_rsp_if.source         rsp_ch
);

   localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CW = $clog2(NUM_BLOCKS + 1);

   // request capture
   logic              op_ff, op_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic [IDX_W-1:0]  index_ff, index_in;
   // scan and write state
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [NEED_W-1:0] run_len_ff, run_len_in;
   logic [AW-1:0]     start_ff, start_in;
   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        status_ff, status_in;
   logic [IDX_W-1:0]  start_block_ff, start_block_in;
   logic              busy_ff, busy_in;
   logic [IDX_W-1:0]  next_ff, next_in;
   logic              end_ff, end_in;

   // table RAM port signals
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [ENTRY_W-1:0] rd_data;

   logic               rd_busy;
   logic               idx_ok;
   logic               wr_last;
   logic               accept;
   logic               slot_free;
   logic [CW-1:0]      cnt_inc;

   cbac_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_BLOCKS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_busy   = rd_data[ENTRY_W-1];
   assign idx_ok    = 32'(index_ff) < NUM_BLOCKS;
   assign wr_last   = run_len_ff == NEED_W'(1);
   assign cnt_inc   = cnt_ff + 1'b1;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign accept    = (ctrl.act == ACT_ACCEPT) && req_ch.valid;

   assign req_ch.ready = (ctrl.act == ACT_ACCEPT);

   assign flags.req_valid = req_ch.valid;
   assign flags.op_read   = op_ff == OP_READ;
   assign flags.too_big   = 32'(need_ff) > NUM_BLOCKS;
   assign flags.found     = !rd_busy && (run_len_ff + 1'b1 == need_ff);
   assign flags.cnt_end   = 32'(cnt_ff) == NUM_BLOCKS;
   assign flags.wr_last   = wr_last;
   assign flags.clr_last  = 32'(cnt_ff) == NUM_BLOCKS - 1;
   assign flags.slot_free = slot_free;

   // RAM ports
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cnt_ff[AW-1:0];
      wr_data = '0;
      rd_en   = 1'b0;
      rd_addr = cnt_ff[AW-1:0];
      case (ctrl.act)
         ACT_CLR: begin
            wr_en = 1'b1;
         end
         ACT_WR: begin
            wr_en   = 1'b1;
            wr_data = {1'b1, (wr_last ? IDX_W'(0) : IDX_W'(cnt_inc)), wr_last};
         end
         ACT_SCAN_RD: begin
            rd_en = 1'b1;
         end
         ACT_RD_ISSUE: begin
            rd_en   = 1'b1;
            rd_addr = AW'(index_ff);
         end
         default: begin
         end
      endcase
   end

   // sequenced datapath updates
   always_comb begin
      op_in          = op_ff;
      need_in        = need_ff;
      index_in       = index_ff;
      cnt_in         = cnt_ff;
      run_len_in     = run_len_ff;
      start_in       = start_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      status_in      = status_ff;
      start_block_in = start_block_ff;
      busy_in        = busy_ff;
      next_in        = next_ff;
      end_in         = end_ff;
      case (ctrl.act)
         ACT_CLR: begin
            cnt_in = cnt_inc;
         end
         ACT_ACCEPT: begin
            if (accept) begin
               op_in      = req_ch.opcode;
               need_in    = {1'b0, req_ch.size_bytes[SIZE_W-1:BLOCK_SHIFT]} + 1'b1;
               index_in   = req_ch.entry_index;
               cnt_in     = '0;
               run_len_in = '0;
               start_in   = '0;
            end
         end
         ACT_SCAN_EV: begin
            cnt_in = cnt_inc;
            if (rd_busy) begin
               run_len_in = '0;
               start_in   = AW'(cnt_inc);
            end else begin
               run_len_in = run_len_ff + 1'b1;
            end
         end
         ACT_WR_INIT: begin
            cnt_in = CW'(start_ff);
         end
         ACT_WR: begin
            cnt_in     = cnt_inc;
            run_len_in = run_len_ff - 1'b1;
         end
         ACT_RSP_NOROOM: begin
            rsp_valid_in   = 1'b1;
            status_in      = STAT_NOROOM;
            start_block_in = '0;
            busy_in        = 1'b0;
            next_in        = '0;
            end_in         = 1'b0;
         end
         ACT_RSP_OK: begin
            rsp_valid_in   = 1'b1;
            status_in      = STAT_ALLOC;
            start_block_in = IDX_W'(start_ff);
            busy_in        = 1'b0;
            next_in        = '0;
            end_in         = 1'b0;
         end
         ACT_RSP_READ: begin
            rsp_valid_in   = 1'b1;
            status_in      = STAT_READ;
            start_block_in = '0;
            if (idx_ok && rd_busy) begin
               busy_in = 1'b1;
               next_in = rd_data[ENTRY_W-2:1];
               end_in  = rd_data[0];
            end else begin
               busy_in = 1'b0;
               next_in = '0;
               end_in  = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      need_ff        <= need_in;
      index_ff       <= index_in;
      run_len_ff     <= run_len_in;
      start_ff       <= start_in;
      status_ff      <= status_in;
      start_block_ff <= start_block_in;
      busy_ff        <= busy_in;
      next_ff        <= next_in;
      end_ff         <= end_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.start_block = start_block_ff;
   assign rsp_ch.entry_busy  = busy_ff;
   assign rsp_ch.entry_next  = next_ff;
   assign rsp_ch.entry_end   = end_ff;

endmodule

`default_nettype wire

>>> rtl/contiguous_block_allocator_with_chain_core.sv
// First-fit contiguous block allocator with a chained block table.
// Reset (synchronous) starts a clearing pass over every table entry; no request
// is taken until it ends. Read: one table entry is fetched and returned. Allocate: the
// table is scanned block by block for a free run, then the chain is written; a full
// scan with no free run answers no room, and an oversize file gets no room without a scan.
// One request at a time; the next request is taken while a response waits in its register.
`default_nettype none

module contiguous_block_allocator_with_chain_core import cbac_pkg::*; #(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   cbac_req_if.sink   req_ch,
   cbac_rsp_if.source rsp_ch
);

   // The sequencer steps through a small control program:
   //   clear the table, wait for a request, dispatch on opcode (a read fetches
   //   one entry), check the size, scan for a free run (read, evaluate, advance),
   //   write the chain, then load the response register and return to wait.
   // The datapath reports flags back for the conditional jumps.

   ctrl_word_type ctrl;
   dp_flags_type  flags;

   cbac_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   // Hold the table, counters and response register; drive the handshakes.
   cbac_dp #(.NUM_BLOCKS(NUM_BLOCKS)) u_dp (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .flags  (flags),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule

`default_nettype wire
